FILE: hdl/frictional_contact_force_assert.svh
// ----------------------------------------------------------------------------
// frictional contact force assertion macros
// shared concurrent assertion forms for the contact force block
// ----------------------------------------------------------------------------
`ifndef FRICTIONAL_CONTACT_FORCE_ASSERT_SVH
`define FRICTIONAL_CONTACT_FORCE_ASSERT_SVH

// same-cycle implication
`define FCF_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("frictional_contact_force: assertion failed");

// next-cycle implication
`define FCF_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("frictional_contact_force: assertion failed");

`endif

FILE: hdl/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg
// types, constants and helpers of the frictional contact force block
// ----------------------------------------------------------------------------
`default_nettype none

package fcf_pkg;

   localparam int PARTICLE_COUNT_DEF = 1024;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_STIFFNESS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TANGENTIAL_STIFFNESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRICTION_COEFFICIENT = 2'd2;

   localparam int MUL_A_W = 50;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = 68;

   localparam int RD_OPA_W = 64;
   localparam int RD_RES_W = 32;
   localparam int RD_REM_W = 36;

   localparam logic [31:0] NO_CONTACT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic start;
      logic root;
   } rd_cmd_type;

   typedef struct packed {
      logic                done;
      logic [RD_RES_W-1:0] value;
   } rd_rsp_type;

   typedef struct packed {
      logic        [31:0] expected;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] shear_x;
      logic signed [31:0] shear_y;
      logic signed [31:0] shear_z;
   } row_type;

   function automatic logic signed [31:0] sat32(input logic signed [MUL_P_W-1:0] x);
      logic signed [31:0] r;
      if (!x[MUL_P_W-1] && (|x[MUL_P_W-2:31])) begin
         r = 32'sh7FFF_FFFF;
      end else if (x[MUL_P_W-1] && !(&x[MUL_P_W-2:31])) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      logic [31:0] r;
      if (x[31]) begin
         r = 32'(-x);
      end else begin
         r = x;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/fcf_ram.sv
// ----------------------------------------------------------------------------
// fcf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fcf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/fcf_mul.sv
// ----------------------------------------------------------------------------
// fcf_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module fcf_mul
   import fcf_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic signed [MUL_A_W-1:0] a,
   input  wire logic signed [MUL_B_W-1:0] b,
   output logic signed      [MUL_P_W-1:0] prod
);

   logic signed [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(a) * MUL_P_W'(b);
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: hdl/fcf_rootdiv.sv
// ----------------------------------------------------------------------------
// fcf_rootdiv
// shared bit-serial unit: floor square root of a 64 bit word, or a
// 64 by 32 bit divide with a 32 bit quotient, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fcf_rootdiv
   import fcf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rd_cmd_type          cmd,
   input  wire logic [RD_OPA_W-1:0] opa,
   input  wire logic [RD_RES_W-1:0] divisor,
   output rd_rsp_type               rsp
);

   localparam int CNT_W = $clog2(RD_RES_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                mode_ff, mode_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [RD_REM_W-1:0] rem_ff, rem_in;
   logic [RD_OPA_W-1:0] src_ff, src_in;
   logic [RD_RES_W-1:0] res_ff, res_in;
   logic [RD_RES_W-1:0] dvs_ff, dvs_in;

   logic [RD_REM_W-1:0] shifted;
   logic [RD_REM_W-1:0] trial;
   logic                ge;

   always_comb begin
      if (mode_ff) begin
         shifted = {rem_ff[RD_REM_W-3:0], src_ff[RD_OPA_W-1 -: 2]};
         trial   = {2'b00, res_ff, 2'b01};
      end else begin
         shifted = {rem_ff[RD_REM_W-2:0], src_ff[RD_OPA_W-1]};
         trial   = RD_REM_W'(dvs_ff);
      end
      ge = (shifted >= trial);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      src_in  = src_ff;
      res_in  = res_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.root;
         cnt_in  = '1;
         res_in  = '0;
         dvs_in  = divisor;
         if (cmd.root) begin
            rem_in = '0;
            src_in = opa;
         end else begin
            rem_in = RD_REM_W'(opa[RD_OPA_W-1:RD_RES_W]);
            src_in = {opa[RD_RES_W-1:0], {(RD_OPA_W-RD_RES_W){1'b0}}};
         end
      end else if (busy_ff) begin
         rem_in = ge ? (shifted - trial) : shifted;
         res_in = {res_ff[RD_RES_W-2:0], ge};
         src_in = mode_ff ? (src_ff << 2) : (src_ff << 1);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      res_ff  <= res_in;
      dvs_ff  <= dvs_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

`default_nettype wire

FILE: hdl/frictional_contact_force.sv
// ----------------------------------------------------------------------------
// frictional_contact_force
// penalty contact force with Coulomb friction and per-particle shear history
// ----------------------------------------------------------------------------
// throughput: one word at a time, limited by the shared bit-serial root and
// divide unit, which each word uses for two roots and up to three divides
// reset: clears the control and configuration registers, then a clearing
// pass writes every row of the history ram; no word is accepted until it ends
`default_nettype none

`include "frictional_contact_force_assert.svh"

module frictional_contact_force
   import fcf_pkg::*;
#(
   parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [9:0]           req_particle_index,
   input  wire logic [31:0]          req_step_index,
   input  wire logic signed [31:0]   req_penetration,
   input  wire logic signed [15:0]   req_normal_x,
   input  wire logic signed [15:0]   req_normal_y,
   input  wire logic signed [15:0]   req_normal_z,
   input  wire logic signed [31:0]   req_contact_x,
   input  wire logic signed [31:0]   req_contact_y,
   input  wire logic signed [31:0]   req_contact_z,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [31:0]        rsp_force_x,
   output logic signed [31:0]        rsp_force_y,
   output logic signed [31:0]        rsp_force_z
);

   localparam int ADDR_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
   localparam int ROW_W  = $bits(row_type);
   localparam int ST_W   = 6;

   localparam logic [ST_W-1:0] S_CLR   = 6'd0;
   localparam logic [ST_W-1:0] S_IDLE  = 6'd1;
   localparam logic [ST_W-1:0] S_F_H   = 6'd2;
   localparam logic [ST_W-1:0] S_F_L   = 6'd3;
   localparam logic [ST_W-1:0] S_F_SUM = 6'd4;
   localparam logic [ST_W-1:0] S_FN_X  = 6'd5;
   localparam logic [ST_W-1:0] S_FN_Y  = 6'd6;
   localparam logic [ST_W-1:0] S_FN_Z  = 6'd7;
   localparam logic [ST_W-1:0] S_DOT_X = 6'd8;
   localparam logic [ST_W-1:0] S_DOT_Y = 6'd9;
   localparam logic [ST_W-1:0] S_DOT_Z = 6'd10;
   localparam logic [ST_W-1:0] S_DOT_E = 6'd11;
   localparam logic [ST_W-1:0] S_NL_X  = 6'd12;
   localparam logic [ST_W-1:0] S_NL_Y  = 6'd13;
   localparam logic [ST_W-1:0] S_NL_Z  = 6'd14;
   localparam logic [ST_W-1:0] S_KH    = 6'd15;
   localparam logic [ST_W-1:0] S_KL    = 6'd16;
   localparam logic [ST_W-1:0] S_SH_Z  = 6'd17;
   localparam logic [ST_W-1:0] S_MAG   = 6'd18;
   localparam logic [ST_W-1:0] S_SQ_H  = 6'd19;
   localparam logic [ST_W-1:0] S_SQ_L  = 6'd20;
   localparam logic [ST_W-1:0] S_SQ_E  = 6'd21;
   localparam logic [ST_W-1:0] S_ROOT  = 6'd22;
   localparam logic [ST_W-1:0] S_LIM   = 6'd23;
   localparam logic [ST_W-1:0] S_LIM_E = 6'd24;
   localparam logic [ST_W-1:0] S_CMP   = 6'd25;
   localparam logic [ST_W-1:0] S_SC_H  = 6'd26;
   localparam logic [ST_W-1:0] S_SC_L  = 6'd27;
   localparam logic [ST_W-1:0] S_SC_E  = 6'd28;
   localparam logic [ST_W-1:0] S_DIV   = 6'd29;
   localparam logic [ST_W-1:0] S_OUT   = 6'd30;

   logic [ST_W-1:0]   state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic [31:0] ns_ff, ns_in;
   logic [31:0] kt_ff, kt_in;
   logic [15:0] fc_ff, fc_in;

   logic [ADDR_W-1:0]  pidx_ff, pidx_in;
   logic               ok_ff, ok_in;
   logic               cont_ff, cont_in;
   logic [31:0]        stp_ff, stp_in;
   logic signed [31:0] d_ff, d_in;
   logic signed [15:0] nv_ff [3];
   logic signed [15:0] nv_in [3];
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];

   logic signed [32:0]        r_ff [3];
   logic signed [32:0]        r_in [3];
   logic signed [47:0]        f_ff, f_in;
   logic signed [31:0]        nc_ff [3];
   logic signed [31:0]        nc_in [3];
   logic signed [MUL_P_W-1:0] acc_ff, acc_in;
   logic signed [MUL_P_W-1:0] hold_ff, hold_in;
   logic signed [36:0]        nl_ff, nl_in;
   logic signed [39:0]        rt_ff [3];
   logic signed [39:0]        rt_in [3];
   logic signed [31:0]        sh_ff [3];
   logic signed [31:0]        sh_in [3];
   logic [31:0]               mag_ff [3];
   logic [31:0]               mag_in [3];
   logic                      pass_ff, pass_in;
   logic [1:0]                cnt_ff, cnt_in;
   logic [31:0]               tl_ff, tl_in;
   logic [31:0]               nmag_ff, nmag_in;
   logic [35:0]               lim_ff, lim_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] fout_ff [3];
   logic signed [31:0] fout_in [3];

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;
   logic signed [MUL_P_W-1:0] sum_acc;
   logic [1:0]                cm1;

   rd_cmd_type rd_cmd;
   rd_rsp_type rd_rsp;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   row_type           wr_row;
   row_type           rd_row;
   logic [ROW_W-1:0]  ram_rdata;
   logic              accept;
   logic              out_free;
   logic signed [31:0] sh_fin [3];

   fcf_ram #(
      .WIDTH (ROW_W),
      .DEPTH (PARTICLE_COUNT)
   ) u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_row),
      .re    (accept),
      .raddr (ADDR_W'(req_particle_index)),
      .rdata (ram_rdata)
   );

   fcf_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   fcf_rootdiv u_rootdiv (
      .clock   (clock),
      .reset   (reset),
      .cmd     (rd_cmd),
      .opa     (sum_acc[RD_OPA_W-1:0]),
      .divisor (tl_ff),
      .rsp     (rd_rsp)
   );

   assign rd_row    = row_type'(ram_rdata);
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sum_acc   = acc_ff + prod;
   assign cm1       = cnt_ff - 2'd1;

   assign rd_cmd.start = (state_ff == S_SQ_E) || (state_ff == S_SC_E);
   assign rd_cmd.root  = (state_ff == S_SQ_E);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh_fin[i] = cont_ff ? sh_ff[i] : 32'sd0;
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = pidx_ff;
      wr_row.expected = stp_ff + 32'd1;
      wr_row.pos_x    = pos_ff[0];
      wr_row.pos_y    = pos_ff[1];
      wr_row.pos_z    = pos_ff[2];
      wr_row.shear_x  = sh_fin[0];
      wr_row.shear_y  = sh_fin[1];
      wr_row.shear_z  = sh_fin[2];
      if (state_ff == S_CLR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         wr_row.expected = NO_CONTACT;
         wr_row.pos_x    = '0;
         wr_row.pos_y    = '0;
         wr_row.pos_z    = '0;
         wr_row.shear_x  = '0;
         wr_row.shear_y  = '0;
         wr_row.shear_z  = '0;
      end else if (state_ff == S_OUT) begin
         ram_we = out_free && ok_ff;
      end
   end

   always_comb begin
      ns_in = ns_ff;
      kt_in = kt_ff;
      fc_in = fc_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_NORMAL_STIFFNESS:     ns_in = csr_wdata;
            CSR_TANGENTIAL_STIFFNESS: kt_in = csr_wdata;
            CSR_FRICTION_COEFFICIENT: fc_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      pidx_in  = pidx_ff;
      ok_in    = ok_ff;
      cont_in  = cont_ff;
      stp_in   = stp_ff;
      d_in     = d_ff;
      nv_in    = nv_ff;
      pos_in   = pos_ff;
      r_in     = r_ff;
      f_in     = f_ff;
      nc_in    = nc_ff;
      acc_in   = acc_ff;
      hold_in  = hold_ff;
      nl_in    = nl_ff;
      rt_in    = rt_ff;
      sh_in    = sh_ff;
      mag_in   = mag_ff;
      pass_in  = pass_ff;
      cnt_in   = cnt_ff;
      tl_in    = tl_ff;
      nmag_in  = nmag_ff;
      lim_in   = lim_ff;
      fout_in  = fout_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a    = '0;
      mul_b    = '0;

      case (state_ff)
         S_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(PARTICLE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               pidx_in   = ADDR_W'(req_particle_index);
               ok_in     = (32'(req_particle_index) < 32'(PARTICLE_COUNT));
               stp_in    = req_step_index;
               d_in      = req_penetration;
               nv_in[0]  = req_normal_x;
               nv_in[1]  = req_normal_y;
               nv_in[2]  = req_normal_z;
               pos_in[0] = req_contact_x;
               pos_in[1] = req_contact_y;
               pos_in[2] = req_contact_z;
               state_in  = S_F_H;
            end
         end
         S_F_H: begin
            cont_in  = ok_ff && (rd_row.expected != NO_CONTACT) &&
                       (rd_row.expected == stp_ff);
            r_in[0]  = 33'(pos_ff[0]) - 33'(rd_row.pos_x);
            r_in[1]  = 33'(pos_ff[1]) - 33'(rd_row.pos_y);
            r_in[2]  = 33'(pos_ff[2]) - 33'(rd_row.pos_z);
            sh_in[0] = rd_row.shear_x;
            sh_in[1] = rd_row.shear_y;
            sh_in[2] = rd_row.shear_z;
            mul_a    = MUL_A_W'(d_ff);
            mul_b    = MUL_B_W'(ns_ff[31:16]);
            state_in = S_F_L;
         end
         S_F_L: begin
            acc_in   = prod;
            mul_a    = MUL_A_W'(d_ff);
            mul_b    = MUL_B_W'(ns_ff[15:0]);
            state_in = S_F_SUM;
         end
         S_F_SUM: begin
            f_in     = 48'(acc_ff + (prod >>> 16));
            state_in = S_FN_X;
         end
         S_FN_X: begin
            mul_a    = MUL_A_W'(f_ff);
            mul_b    = MUL_B_W'(nv_ff[0]);
            state_in = S_FN_Y;
         end
         S_FN_Y: begin
            nc_in[0] = sat32(prod >>> 14);
            mul_a    = MUL_A_W'(f_ff);
            mul_b    = MUL_B_W'(nv_ff[1]);
            state_in = S_FN_Z;
         end
         S_FN_Z: begin
            nc_in[1] = sat32(prod >>> 14);
            mul_a    = MUL_A_W'(f_ff);
            mul_b    = MUL_B_W'(nv_ff[2]);
            state_in = S_DOT_X;
         end
         S_DOT_X: begin
            nc_in[2] = sat32(prod >>> 14);
            mul_a    = MUL_A_W'(r_ff[0]);
            mul_b    = MUL_B_W'(nv_ff[0]);
            state_in = S_DOT_Y;
         end
         S_DOT_Y: begin
            acc_in   = prod;
            mul_a    = MUL_A_W'(r_ff[1]);
            mul_b    = MUL_B_W'(nv_ff[1]);
            state_in = S_DOT_Z;
         end
         S_DOT_Z: begin
            acc_in   = sum_acc;
            mul_a    = MUL_A_W'(r_ff[2]);
            mul_b    = MUL_B_W'(nv_ff[2]);
            state_in = S_DOT_E;
         end
         S_DOT_E: begin
            nl_in    = 37'(sum_acc >>> 14);
            state_in = S_NL_X;
         end
         S_NL_X: begin
            mul_a    = MUL_A_W'(nl_ff);
            mul_b    = MUL_B_W'(nv_ff[0]);
            state_in = S_NL_Y;
         end
         S_NL_Y: begin
            rt_in[0] = 40'(r_ff[0]) - 40'(prod >>> 14);
            mul_a    = MUL_A_W'(nl_ff);
            mul_b    = MUL_B_W'(nv_ff[1]);
            state_in = S_NL_Z;
         end
         S_NL_Z: begin
            rt_in[1] = 40'(r_ff[1]) - 40'(prod >>> 14);
            mul_a    = MUL_A_W'(nl_ff);
            mul_b    = MUL_B_W'(nv_ff[2]);
            cnt_in   = 2'd0;
            state_in = S_KH;
         end
         S_KH: begin
            if (cnt_ff == 2'd0) begin
               rt_in[2] = 40'(r_ff[2]) - 40'(prod >>> 14);
            end else begin
               sh_in[cm1] = sat32(hold_ff + (prod >>> 16));
            end
            mul_a    = MUL_A_W'(rt_ff[cnt_ff]);
            mul_b    = MUL_B_W'(kt_ff[31:16]);
            state_in = S_KL;
         end
         S_KL: begin
            hold_in = MUL_P_W'(sh_ff[cnt_ff]) + prod;
            mul_a   = MUL_A_W'(rt_ff[cnt_ff]);
            mul_b   = MUL_B_W'(kt_ff[15:0]);
            if (cnt_ff == 2'd2) begin
               state_in = S_SH_Z;
            end else begin
               cnt_in   = cnt_ff + 2'd1;
               state_in = S_KH;
            end
         end
         S_SH_Z: begin
            sh_in[2] = sat32(hold_ff + (prod >>> 16));
            pass_in  = 1'b0;
            state_in = S_MAG;
         end
         S_MAG: begin
            for (int i = 0; i < 3; i++) begin
               mag_in[i] = pass_ff ? mag32(sh_ff[i]) : mag32(nc_ff[i]);
            end
            acc_in   = '0;
            cnt_in   = 2'd0;
            state_in = S_SQ_H;
         end
         S_SQ_H: begin
            if (cnt_ff != 2'd0) begin
               acc_in = sum_acc;
            end
            mul_a    = MUL_A_W'(mag_ff[cnt_ff]);
            mul_b    = MUL_B_W'(mag_ff[cnt_ff][31:16]);
            state_in = S_SQ_L;
         end
         S_SQ_L: begin
            acc_in = acc_ff + (prod <<< 16);
            mul_a  = MUL_A_W'(mag_ff[cnt_ff]);
            mul_b  = MUL_B_W'(mag_ff[cnt_ff][15:0]);
            if (cnt_ff == 2'd2) begin
               state_in = S_SQ_E;
            end else begin
               cnt_in   = cnt_ff + 2'd1;
               state_in = S_SQ_H;
            end
         end
         S_SQ_E: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (rd_rsp.done) begin
               if (!pass_ff) begin
                  nmag_in  = rd_rsp.value;
                  pass_in  = 1'b1;
                  state_in = S_MAG;
               end else begin
                  tl_in    = rd_rsp.value;
                  state_in = S_LIM;
               end
            end
         end
         S_LIM: begin
            mul_a    = MUL_A_W'(nmag_ff);
            mul_b    = MUL_B_W'(fc_ff);
            state_in = S_LIM_E;
         end
         S_LIM_E: begin
            lim_in   = 36'(prod >>> 12);
            state_in = S_CMP;
         end
         S_CMP: begin
            cnt_in = 2'd0;
            if (cont_ff && (36'(tl_ff) > lim_ff)) begin
               state_in = S_SC_H;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SC_H: begin
            mul_a    = MUL_A_W'(lim_ff);
            mul_b    = MUL_B_W'(mag_ff[cnt_ff][31:16]);
            state_in = S_SC_L;
         end
         S_SC_L: begin
            acc_in   = prod <<< 16;
            mul_a    = MUL_A_W'(lim_ff);
            mul_b    = MUL_B_W'(mag_ff[cnt_ff][15:0]);
            state_in = S_SC_E;
         end
         S_SC_E: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rd_rsp.done) begin
               sh_in[cnt_ff] = sh_ff[cnt_ff][31] ? 32'(-rd_rsp.value) : rd_rsp.value;
               if (cnt_ff == 2'd2) begin
                  state_in = S_OUT;
               end else begin
                  cnt_in   = cnt_ff + 2'd1;
                  state_in = S_SC_H;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               for (int i = 0; i < 3; i++) begin
                  fout_in[i] = sat32(MUL_P_W'(nc_ff[i]) + MUL_P_W'(sh_fin[i]));
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         ns_ff        <= '0;
         kt_ff        <= '0;
         fc_ff        <= '0;
         cont_ff      <= 1'b0;
         ok_ff        <= 1'b0;
         pass_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ns_ff        <= ns_in;
         kt_ff        <= kt_in;
         fc_ff        <= fc_in;
         cont_ff      <= cont_in;
         ok_ff        <= ok_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pidx_ff <= pidx_in;
      stp_ff  <= stp_in;
      d_ff    <= d_in;
      nv_ff   <= nv_in;
      pos_ff  <= pos_in;
      r_ff    <= r_in;
      f_ff    <= f_in;
      nc_ff   <= nc_in;
      acc_ff  <= acc_in;
      hold_ff <= hold_in;
      nl_ff   <= nl_in;
      rt_ff   <= rt_in;
      sh_ff   <= sh_in;
      mag_ff  <= mag_in;
      tl_ff   <= tl_in;
      nmag_ff <= nmag_in;
      lim_ff  <= lim_in;
      fout_ff <= fout_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_force_x = fout_ff[0];
   assign rsp_force_y = fout_ff[1];
   assign rsp_force_z = fout_ff[2];

   `FCF_ASSERT_IMPLY(a_ram_write_state, clock, reset, ram_we, (state_ff == S_OUT) || (state_ff == S_CLR))
   `FCF_ASSERT_IMPLY(a_rootdiv_done_waited, clock, reset, rd_rsp.done, (state_ff == S_ROOT) || (state_ff == S_DIV))
   `FCF_ASSERT_NEXT(a_out_word_shown, clock, reset, (state_ff == S_OUT) && out_free, rsp_valid && (state_ff == S_IDLE))

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// frictional contact force testbench
// sends contact words with random gaps and random result stalls, predicts
// each force from a local copy of the per-particle history and checks every
// result word field by field over several stiffness and friction settings
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import fcf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      logic        [9:0]  particle;
      logic        [31:0] step;
      logic signed [31:0] pen;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } contact_type;

   typedef struct packed {
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] fz;
   } force_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   contact_type req = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_force_z;

   // local copy of configuration and history
   logic [31:0] k_normal = '0, k_tangent = '0;
   logic [15:0] mu = '0;
   logic [31:0] hist_step [PARTICLE_COUNT_DEF];
   logic signed [31:0] hist_pos [PARTICLE_COUNT_DEF][3];
   logic signed [31:0] hist_shear [PARTICLE_COUNT_DEF][3];

   force_type expected_forces [$];
   int errors = 0;
   bit quiet = 0;
   int stall_left = 0;

   frictional_contact_force u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_particle_index(req.particle), .req_step_index(req.step),
      .req_penetration(req.pen),
      .req_normal_x(req.nx), .req_normal_y(req.ny), .req_normal_z(req.nz),
      .req_contact_x(req.px), .req_contact_y(req.py), .req_contact_z(req.pz),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y), .rsp_force_z(rsp_force_z)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #60_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic signed [31:0] clamp32(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return x[31:0];
   endfunction

   function automatic longint unsigned magnitude(input logic signed [31:0] x);
      longint v;
      v = longint'(x);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned vec_length(input logic signed [31:0] a,
         input logic signed [31:0] b, input logic signed [31:0] c);
      longint unsigned v, r, bit_w;
      v = magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b)
         + magnitude(c) * magnitude(c);
      r = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= r + bit_w) begin
            v = v - (r + bit_w);
            r = (r >> 1) + bit_w;
         end else begin
            r = r >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return r;
   endfunction

   // computes the force and updates the local history
   function automatic force_type contact_force(input contact_type c);
      longint f, kh, kl, dot, nl, rt, inc;
      longint n [3];
      longint pos [3];
      longint r [3];
      logic signed [31:0] nc [3];
      logic signed [31:0] sh [3];
      longint unsigned tl, lim, q;
      bit cont;
      force_type res;
      n[0] = longint'(c.nx); n[1] = longint'(c.ny); n[2] = longint'(c.nz);
      pos[0] = longint'(c.px); pos[1] = longint'(c.py); pos[2] = longint'(c.pz);
      f = (longint'({32'd0, k_normal}) * longint'(c.pen)) >>> 16;
      for (int i = 0; i < 3; i++) begin
         nc[i] = clamp32((f * n[i]) >>> 14);
         sh[i] = '0;
      end
      cont = hist_step[c.particle] != NO_CONTACT && hist_step[c.particle] == c.step;
      if (cont) begin
         dot = 0;
         for (int i = 0; i < 3; i++) begin
            r[i] = pos[i] - longint'(hist_pos[c.particle][i]);
            dot += r[i] * n[i];
         end
         nl = dot >>> 14;
         kh = longint'({48'd0, k_tangent[31:16]});
         kl = longint'({48'd0, k_tangent[15:0]});
         for (int i = 0; i < 3; i++) begin
            rt = r[i] - ((nl * n[i]) >>> 14);
            inc = rt * kh + ((rt * kl) >>> 16);
            sh[i] = clamp32(longint'(hist_shear[c.particle][i]) + inc);
         end
         tl = vec_length(sh[0], sh[1], sh[2]);
         lim = (vec_length(nc[0], nc[1], nc[2]) * longint'({48'd0, mu})) >> 12;
         if (tl > lim) begin
            for (int i = 0; i < 3; i++) begin
               q = magnitude(sh[i]) * lim / tl;
               sh[i] = sh[i][31] ? -q[31:0] : q[31:0];
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         hist_pos[c.particle][i] = pos[i][31:0];
         hist_shear[c.particle][i] = sh[i];
      end
      hist_step[c.particle] = c.step + 32'd1;
      res.fx = clamp32(longint'(nc[0]) + longint'(sh[0]));
      res.fy = clamp32(longint'(nc[1]) + longint'(sh[1]));
      res.fz = clamp32(longint'(nc[2]) + longint'(sh[2]));
      return res;
   endfunction

   task automatic send_contact(input contact_type c);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      repeat (gap) @(negedge clock);
      req = c;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      expected_forces.push_back(contact_force(c));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_NORMAL_STIFFNESS: k_normal = val;
         CSR_TANGENTIAL_STIFFNESS: k_tangent = val;
         CSR_FRICTION_COEFFICIENT: mu = val[15:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (expected_forces.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_gains(input logic [31:0] kn, input logic [31:0] kt,
         input logic [15:0] fc);
      wait_idle();
      write_csr(CSR_NORMAL_STIFFNESS, kn);
      write_csr(CSR_TANGENTIAL_STIFFNESS, kt);
      write_csr(CSR_FRICTION_COEFFICIENT, {16'd0, fc});
   endtask

   function automatic logic signed [15:0] rand_normal();
      return 16'($urandom_range(0, 32768)) - 16'sd16384;
   endfunction

   function automatic contact_type rand_contact(input bit wide);
      contact_type c;
      c.particle = wide ? 10'($urandom) : 10'($urandom_range(0, 7));
      c.step = $urandom;
      c.pen = wide ? $urandom : 32'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      c.nx = rand_normal();
      c.ny = rand_normal();
      c.nz = rand_normal();
      if (wide || hist_step[c.particle] == NO_CONTACT) begin
         c.px = $urandom; c.py = $urandom; c.pz = $urandom;
      end else begin
         c.px = hist_pos[c.particle][0] + 32'($urandom_range(0, 8192)) - 32'sd4096;
         c.py = hist_pos[c.particle][1] + 32'($urandom_range(0, 8192)) - 32'sd4096;
         c.pz = hist_pos[c.particle][2] + 32'($urandom_range(0, 8192)) - 32'sd4096;
      end
      return c;
   endfunction

   // directed: field extremes, index all ones, no-contact marker, saturation
   task automatic test_extremes();
      contact_type c;
      c = '{10'd1023, 32'd5, 32'sh7FFF_FFFF, 16'sd16384, -16'sd16384, 16'sd0,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0};
      send_contact(c);
      c.step = 32'd6; c.pen = 32'sh8000_0000; c.px = 32'sh8000_0000; c.py = 32'sh7FFF_FFFF;
      send_contact(c);
      c.step = 32'd7; c.nx = -16'sd16384; c.nz = 16'sd16384; c.pen = 32'sd0;
      send_contact(c);
      c = '{10'd0, NO_CONTACT, 32'sh0001_0000, 16'sd0, 16'sd0, 16'sd16384,
            32'sd100, 32'sd200, 32'sd300};
      send_contact(c);
      send_contact(c);
      c.step = 32'd0;
      send_contact(c);
      c.step = 32'd1; c.px = 32'sh4000_0000; c.pz = -32'sh1000_0000;
      send_contact(c);
      c.step = 32'd2; c.px = -32'sh4000_0000; c.pen = -32'sh0100_0000;
      send_contact(c);
   endtask

   // directed: short continuing sequences, several per particle
   task automatic test_continuing();
      contact_type c;
      for (int p = 0; p < 4; p++) begin
         c = rand_contact(0);
         c.particle = 10'(p);
         c.step = 32'hFFFF_FFFD + 32'(p);
         for (int k = 0; k < 4; k++) begin
            send_contact(c);
            c = rand_contact(0);
            c.particle = 10'(p);
            c.step = hist_step[p];
         end
      end
   endtask

   // random: mostly continuing contacts, some fresh or broken ones
   task automatic test_random(input int count);
      contact_type c;
      for (int k = 0; k < count; k++) begin
         if (k % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
         c = rand_contact($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 9) < 8 && hist_step[c.particle] != NO_CONTACT)
            c.step = hist_step[c.particle];
         send_contact(c);
      end
      quiet = 0;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      force_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_forces.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            e = expected_forces.pop_front();
            if (rsp_force_x !== e.fx) begin
               $error("force_x expected %0d actual %0d", e.fx, rsp_force_x);
               errors++;
            end
            if (rsp_force_y !== e.fy) begin
               $error("force_y expected %0d actual %0d", e.fy, rsp_force_y);
               errors++;
            end
            if (rsp_force_z !== e.fz) begin
               $error("force_z expected %0d actual %0d", e.fz, rsp_force_z);
               errors++;
            end
         end
         stall_left = quiet ? 0 : $urandom_range(0, 15);
      end
   end

   initial begin
      for (int i = 0; i < PARTICLE_COUNT_DEF; i++) begin
         hist_step[i] = NO_CONTACT;
         for (int j = 0; j < 3; j++) begin
            hist_pos[i][j] = '0;
            hist_shear[i][j] = '0;
         end
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      set_gains(32'h0001_0000, 32'h0000_4000, 16'h0800);
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      test_extremes();
      test_continuing();
      test_random(400);
      set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      test_extremes();
      test_random(300);
      set_gains(32'h0010_0000, 32'h0002_0000, 16'h0000);
      test_random(300);
      set_gains($urandom, $urandom, 16'($urandom));
      test_random(300);
      set_gains(32'h0000_8000, 32'h0100_0000, 16'h1000);
      test_random(300);
      set_gains(32'd0, 32'd0, 16'd0);
      test_random(200);
      wait_idle();
      if (errors == 0 && expected_forces.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
